[rtl/core/dcmbe_pkg.sv]
// ----------------------------------------------------------------------------
// dcmbe_pkg
// Shared types and constants for the dual-channel magnetometer band envelope.
// ----------------------------------------------------------------------------
package dcmbe_pkg;

  // Field widths of the sample and of the filter values.
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned AVG_W    = 14;
  localparam int unsigned ENV_W    = 15;

  // Leaky filter shifts.
  localparam int unsigned FAST_SHIFT = 4;
  localparam int unsigned SLOW_SHIFT = 6;
  localparam int unsigned DIFF_SHIFT = 2;
  localparam int unsigned ENV_SHIFT  = 7;

  // Envelope saturation value: all ones at the envelope width.
  localparam logic [ENV_W-1:0] ENV_MAX = '1;

  // Configuration port layout.
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned REG_SEL_LSB = 2;
  localparam logic        REG_HIGH_THR = 1'b0;
  localparam logic        REG_LOW_THR  = 1'b1;

  // Reset values of the thresholds.
  localparam logic [SAMPLE_W-1:0] HIGH_THR_RESET = 10'd793;
  localparam logic [SAMPLE_W-1:0] LOW_THR_RESET  = 10'd230;

  // Potentiometer step request codes.
  typedef enum logic [1:0] {
    POT_NONE = 2'd0,
    POT_DEC  = 2'd1,
    POT_INC  = 2'd2
  } pot_step_t;

  // Per-channel filter state as held in the state memory.
  typedef struct packed {
    logic [AVG_W-1:0] fast;
    logic [AVG_W-1:0] slow;
    logic [ENV_W-1:0] env;
  } state_t;

  localparam int unsigned STATE_W = $bits(state_t);

  // Sums one bit wider than the value they update.
  typedef logic [AVG_W:0] avg_sum_t;
  typedef logic [ENV_W:0] env_sum_t;

endpackage

[rtl/core/dcmbe_ram.sv]
// ----------------------------------------------------------------------------
// dcmbe_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dcmbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/dcmbe_update.sv]
// ----------------------------------------------------------------------------
// dcmbe_update
// One update of the three cascaded leaky filters of a channel.
// ----------------------------------------------------------------------------
module dcmbe_update (
  input  dcmbe_pkg::state_t                  old_state,
  input  logic [dcmbe_pkg::SAMPLE_W-1:0]     sample,
  output dcmbe_pkg::state_t                  new_state
);

  dcmbe_pkg::avg_sum_t                fast_sum;
  dcmbe_pkg::avg_sum_t                slow_sum;
  dcmbe_pkg::env_sum_t                env_sum;
  logic [dcmbe_pkg::AVG_W-1:0]        fast_new;
  logic [dcmbe_pkg::AVG_W-1:0]        slow_new;
  logic [dcmbe_pkg::AVG_W-1:0]        band_diff;

  always_comb begin
    fast_sum = dcmbe_pkg::avg_sum_t'(old_state.fast)
             - dcmbe_pkg::avg_sum_t'(old_state.fast >> dcmbe_pkg::FAST_SHIFT)
             + dcmbe_pkg::avg_sum_t'(sample);
    fast_new = fast_sum[dcmbe_pkg::AVG_W-1:0];

    slow_sum = dcmbe_pkg::avg_sum_t'(old_state.slow)
             - dcmbe_pkg::avg_sum_t'(old_state.slow >> dcmbe_pkg::SLOW_SHIFT)
             + dcmbe_pkg::avg_sum_t'(fast_new >> dcmbe_pkg::SLOW_SHIFT);
    slow_new = slow_sum[dcmbe_pkg::AVG_W-1:0];

    band_diff = (fast_new >= slow_new) ? (fast_new - slow_new) : (slow_new - fast_new);

    // The sum cannot exceed twice the maximum, so the carry bit flags overflow.
    env_sum = dcmbe_pkg::env_sum_t'(old_state.env)
            - dcmbe_pkg::env_sum_t'(old_state.env >> dcmbe_pkg::ENV_SHIFT)
            + dcmbe_pkg::env_sum_t'(band_diff >> dcmbe_pkg::DIFF_SHIFT);

    new_state.fast = fast_new;
    new_state.slow = slow_new;
    new_state.env  = env_sum[dcmbe_pkg::ENV_W] ? dcmbe_pkg::ENV_MAX
                                               : env_sum[dcmbe_pkg::ENV_W-1:0];
  end

endmodule

[rtl/core/dual_channel_mag_band_envelope.sv]
// ----------------------------------------------------------------------------
// dual_channel_mag_band_envelope
// Per-channel gain potentiometer requests and a three-stage leaky band
// envelope for a multi-channel magnetometer front end.
// ----------------------------------------------------------------------------
//
//   Port group  Direction  Handshake           Contents
//   in_*        input      in_valid/in_stall   channel tag and 10-bit sample
//   out_*       output     out_valid/out_stall pot step, fast, slow, envelope
//   APB         input      psel/penable        two 10-bit threshold registers
//
// One word is accepted per cycle while in_stall is low. The word's state
// is first read from the state memory into the read stage; from there the
// filter update runs, writes the state back and loads the output register.
// Reset is synchronous and needs no clearing pass: a valid bit per channel
// makes an unwritten entry read as zero. A stalled output holds its word
// while a further word may still wait in the read stage.
//
module dual_channel_mag_band_envelope #(
  parameter int unsigned NUM_CHANNELS = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_channel,
  input  logic [dcmbe_pkg::SAMPLE_W-1:0]    in_sample,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_channel,
  output logic [1:0]                        out_pot_step,
  output logic [dcmbe_pkg::AVG_W-1:0]       out_fast_average,
  output logic [dcmbe_pkg::AVG_W-1:0]       out_slow_average,
  output logic [dcmbe_pkg::ENV_W-1:0]       out_envelope,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dcmbe_pkg::PADDR_W-1:0]     paddr,
  input  logic [dcmbe_pkg::PDATA_W-1:0]     pwdata,
  output logic [dcmbe_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Configuration registers.
  logic [dcmbe_pkg::SAMPLE_W-1:0] high_thr_r;
  logic [dcmbe_pkg::SAMPLE_W-1:0] low_thr_r;
  logic                           cfg_write;

  // Input side.
  logic                           in_fire;
  logic [IDX_W-1:0]               in_idx;
  dcmbe_pkg::pot_step_t           in_pot_step;

  // Read stage: the word whose state is being read from memory.
  logic                           s1_valid_r;
  logic                           s1_channel_r;
  logic [IDX_W-1:0]               s1_idx_r;
  logic [dcmbe_pkg::SAMPLE_W-1:0] s1_sample_r;
  dcmbe_pkg::pot_step_t           s1_pot_step_r;
  logic                           s1_advance;

  // Most recent write to the state memory, kept for forwarding.
  logic                           last_valid_r;
  logic [IDX_W-1:0]               last_idx_r;

  // Output register; its state fields double as the forwarding data.
  logic                           out_valid_r;
  logic                           out_channel_r;
  dcmbe_pkg::pot_step_t           out_pot_step_r;
  dcmbe_pkg::state_t              out_state_r;

  logic [NUM_CHANNELS-1:0]        entry_valid_r;
  logic [dcmbe_pkg::STATE_W-1:0]  ram_rdata;
  dcmbe_pkg::state_t              old_state;
  dcmbe_pkg::state_t              new_state;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied
  // high so no transfer is ever held in wait states. Only the register select
  // bit of the address is decoded.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r <= dcmbe_pkg::HIGH_THR_RESET;
      low_thr_r  <= dcmbe_pkg::LOW_THR_RESET;
    end else if (cfg_write) begin
      case (paddr[dcmbe_pkg::REG_SEL_LSB])
        dcmbe_pkg::REG_HIGH_THR: high_thr_r <= pwdata[dcmbe_pkg::SAMPLE_W-1:0];
        dcmbe_pkg::REG_LOW_THR:  low_thr_r  <= pwdata[dcmbe_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[dcmbe_pkg::REG_SEL_LSB])
      dcmbe_pkg::REG_HIGH_THR: prdata = dcmbe_pkg::PDATA_W'(high_thr_r);
      dcmbe_pkg::REG_LOW_THR:  prdata = dcmbe_pkg::PDATA_W'(low_thr_r);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Acceptance and threshold compare. The read stage moves on whenever the
  // output register is empty or is being emptied, so a new word is taken in
  // every cycle unless the output is held and the read stage is full.
  // A sample above the high threshold asks for a decrease even if it is also
  // below the low threshold.
  // --------------------------------------------------------------------------
  assign s1_advance = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_fire    = in_valid && !in_stall;

  // With a single channel every word maps onto entry zero.
  assign in_idx = (NUM_CHANNELS > 1) ? IDX_W'(in_channel) : '0;

  always_comb begin
    in_pot_step = dcmbe_pkg::POT_NONE;
    if (in_sample > high_thr_r) begin
      in_pot_step = dcmbe_pkg::POT_DEC;
    end else if (in_sample < low_thr_r) begin
      in_pot_step = dcmbe_pkg::POT_INC;
    end
  end

  // --------------------------------------------------------------------------
  // State memory: one entry per channel holding all three filter values.
  // It is read when a word is accepted and written when that word leaves the
  // read stage. The read data register only changes on a new read, so a held
  // word keeps its data.
  // --------------------------------------------------------------------------
  dcmbe_ram #(
    .WIDTH (dcmbe_pkg::STATE_W),
    .DEPTH (NUM_CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_advance),
    .waddr (s1_idx_r),
    .wdata (new_state),
    .re    (in_fire),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // The memory returns the old contents when a word reads the entry that is
  // written at the same edge. The last write is therefore forwarded whenever
  // it went to the same channel: it is always that channel's newest value,
  // because no write happens while a word waits in the read stage. An entry
  // never written since reset reads as zero.
  always_comb begin
    if (last_valid_r && (last_idx_r == s1_idx_r)) begin
      old_state = out_state_r;
    end else if (entry_valid_r[s1_idx_r]) begin
      old_state = ram_rdata;
    end else begin
      old_state = '0;
    end
  end

  dcmbe_update u_update (
    .old_state (old_state),
    .sample    (s1_sample_r),
    .new_state (new_state)
  );

  // --------------------------------------------------------------------------
  // Pipeline registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      last_valid_r  <= 1'b0;
      entry_valid_r <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_advance) begin
        out_valid_r             <= 1'b1;
        last_valid_r            <= 1'b1;
        entry_valid_r[s1_idx_r] <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_channel_r  <= in_channel;
      s1_idx_r      <= in_idx;
      s1_sample_r   <= in_sample;
      s1_pot_step_r <= in_pot_step;
    end
    if (s1_advance) begin
      out_channel_r  <= s1_channel_r;
      out_pot_step_r <= s1_pot_step_r;
      out_state_r    <= new_state;
      last_idx_r     <= s1_idx_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_pot_step     = out_pot_step_r;
  assign out_fast_average = out_state_r.fast;
  assign out_slow_average = out_state_r.slow;
  assign out_envelope     = out_state_r.env;

endmodule

[rtl/core/dcmbe_checker.sv]
// ----------------------------------------------------------------------------
// dcmbe_checker
// Port-level checks for the band envelope block, bound to the top level.
// ----------------------------------------------------------------------------
module dcmbe_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_channel,
  input  logic [1:0]                      out_pot_step,
  input  logic [dcmbe_pkg::AVG_W-1:0]     out_fast_average,
  input  logic [dcmbe_pkg::AVG_W-1:0]     out_slow_average,
  input  logic [dcmbe_pkg::ENV_W-1:0]     out_envelope
);

  // A held word stays valid.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // A held word does not change.
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable({out_channel, out_pot_step, out_fast_average,
                                        out_slow_average, out_envelope}))
    else $error("output word changed while stalled");

  // The input side only stalls behind a held output word.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output word");

  // After an accepted word, out_valid is high once the read stage has been passed.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("accepted word did not reach the output");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind dual_channel_mag_band_envelope dcmbe_checker u_dcmbe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_channel      (out_channel),
  .out_pot_step     (out_pot_step),
  .out_fast_average (out_fast_average),
  .out_slow_average (out_slow_average),
  .out_envelope     (out_envelope)
);
